// ===== hw/rtl/bbef_pkg.sv =====
// ----------------------------------------------------------------------------
// bbef_pkg
// shared types and constants of the brace block end finder
// ----------------------------------------------------------------------------
package bbef_pkg;

    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_APOS   = 8'h27;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        CL_OTHER,
        CL_LBRACE,
        CL_RBRACE,
        CL_SLASH,
        CL_STAR,
        CL_QUOTE,
        CL_APOS,
        CL_BSLASH,
        CL_CR,
        CL_LF
    } t_cls;

    typedef struct packed {
        t_cls cls;
        logic last;
    } t_item;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_LEX,
        PH_AFTER_CLOSE,
        PH_AFTER_CR,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_OPEN   = 2'd1,
        ST_UNCLOSED  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/brace_block_end_finder_unit.sv =====
// ----------------------------------------------------------------------------
// brace_block_end_finder_unit
// finds the end of a brace-delimited block in a streamed C-like text
// ----------------------------------------------------------------------------
// Text bytes enter on the slave stream, one byte per transfer, with tlast on
// the final byte of a text. Bytes before the first '{' are skipped; from it on
// comments, string and char literals and brace depth are tracked. After the
// closing brace one optional CR and one optional LF are counted into the span.
// At most one result per text leaves on the master stream: status in the low
// two bits of tdata, then the absolute offset one past the span (zero unless
// found). The user writes the span start offset on the configuration port only
// while the block is idle; the block does not enforce this. Throughput is one
// byte per cycle while the receiver does not stall; a deciding byte passes the
// classifier register, two-entry queue and lexer into the result register.
// When the receiver stalls, the result register holds and the lexer stops; the
// queue and the classifier register then fill and o_s_tready falls. Reset
// empties the pipeline, clears the lexer state and sets the span start to zero.
// ----------------------------------------------------------------------------
module brace_block_end_finder_unit import bbef_pkg::*; #(
    parameter int DEPTH_MAX   = 255,
    parameter int OFFSET_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [OFFSET_BITS-1:0] i_cfg_wdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // text_byte
    input  logic                   i_s_tlast,   // end_of_text
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [((2+OFFSET_BITS+7)/8)*8-1:0] o_m_tdata  // status, span_end
);

    localparam int OUT_W = ((2 + OFFSET_BITS + 7) / 8) * 8;

    logic                   w_f_valid;
    logic                   w_f_ready;
    t_item                  w_f_item;
    logic                   w_q_valid;
    logic                   w_q_ready;
    t_item                  w_q_item;
    t_status                w_status;
    logic [OFFSET_BITS-1:0] w_span_end;

    bbef_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_valid    (w_f_valid),
        .i_ready    (w_f_ready),
        .o_item     (w_f_item)
    );

    bbef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    bbef_back #(
        .DEPTH_MAX   (DEPTH_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_q_valid),
        .o_ready     (w_q_ready),
        .i_item      (w_q_item),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_status    (w_status),
        .o_span_end  (w_span_end)
    );

    assign o_m_tdata = OUT_W'({w_span_end, w_status});

endmodule

// ===== hw/rtl/bbef_front.sv =====
// ----------------------------------------------------------------------------
// bbef_front
// accepts text bytes and classifies them into lexer character classes
// ----------------------------------------------------------------------------
module bbef_front import bbef_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // text_byte
    input  logic        i_s_tlast,   // end_of_text
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_cls  w_cls;

    always_comb begin
        case (i_s_tdata)
            C_LBRACE: w_cls = CL_LBRACE;
            C_RBRACE: w_cls = CL_RBRACE;
            C_SLASH:  w_cls = CL_SLASH;
            C_STAR:   w_cls = CL_STAR;
            C_QUOTE:  w_cls = CL_QUOTE;
            C_APOS:   w_cls = CL_APOS;
            C_BSLASH: w_cls = CL_BSLASH;
            C_CR:     w_cls = CL_CR;
            C_LF:     w_cls = CL_LF;
            default:  w_cls = CL_OTHER;
        endcase
    end

    assign o_s_tready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.cls  <= w_cls;
            r_item.last <= i_s_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/bbef_queue.sv =====
// ----------------------------------------------------------------------------
// bbef_queue
// two-entry queue between the classifier and the lexer
// ----------------------------------------------------------------------------
module bbef_queue import bbef_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        w_push;
    logic        w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/bbef_back.sv =====
// ----------------------------------------------------------------------------
// bbef_back
// lexer state machine, span counter and result register
// ----------------------------------------------------------------------------
module bbef_back import bbef_pkg::*; #(
    parameter int DEPTH_MAX   = 255,
    parameter int OFFSET_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [OFFSET_BITS-1:0] i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_item                  i_item,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output t_status                o_status,
    output logic [OFFSET_BITS-1:0] o_span_end
);

    localparam int DW = $clog2(DEPTH_MAX + 1);
    localparam logic [DW-1:0] DEPTH_LIM = DW'(DEPTH_MAX);

    logic [OFFSET_BITS-1:0] r_span_start;
    t_phase                 r_phase, n_phase, w_phase_mid;
    logic [DW-1:0]          r_depth, n_depth;
    logic [OFFSET_BITS-1:0] r_count, n_count;
    logic                   r_str, r_chr, r_esc, r_line, r_block, r_pslash, r_pstar;
    logic                   n_str, n_chr, n_esc, n_line, n_block, n_pslash, n_pstar;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [OFFSET_BITS-1:0] r_out_span;

    t_cls                   w_cls;
    logic                   w_last;
    logic                   w_pop;
    logic                   w_counts;
    logic                   w_ovf;
    logic                   w_inc;
    logic                   w_plain;
    logic                   w_depth_ovf;
    logic                   w_emit;
    t_status                w_status;
    logic [OFFSET_BITS:0]   w_sum1;
    logic [OFFSET_BITS-1:0] w_sum0;
    logic [OFFSET_BITS-1:0] w_span;

    assign w_cls  = i_item.cls;
    assign w_last = i_item.last;

    assign o_ready = !r_out_valid || i_m_tready;
    assign w_pop   = i_valid && o_ready;

    always_comb begin
        case (r_phase)
            PH_SEEK:        w_counts = 1'b1;
            PH_LEX:         w_counts = 1'b1;
            PH_AFTER_CLOSE: w_counts = (w_cls == CL_CR) || (w_cls == CL_LF);
            PH_AFTER_CR:    w_counts = (w_cls == CL_LF);
            default:        w_counts = 1'b0;
        endcase
    end

    assign w_sum0 = r_span_start + r_count;
    assign w_sum1 = {1'b0, r_span_start} + {1'b0, r_count} + (OFFSET_BITS+1)'(1);
    assign w_ovf  = w_counts && w_sum1[OFFSET_BITS];
    assign w_inc  = w_counts && !w_ovf;
    assign w_span = w_inc ? w_sum1[OFFSET_BITS-1:0] : w_sum0;

    // byte reaches the plain lexer path (not in comment or literal, not a comment opener)
    assign w_plain = !r_line && !r_block && !r_str && !r_chr &&
                     !(r_pslash && ((w_cls == CL_SLASH) || (w_cls == CL_STAR)));
    assign w_depth_ovf = (r_phase == PH_LEX) && w_plain && (w_cls == CL_LBRACE) &&
                         (r_depth >= DEPTH_LIM);

    // next state
    always_comb begin
        w_phase_mid = r_phase;
        n_depth  = r_depth;
        n_count  = w_inc ? (r_count + OFFSET_BITS'(1)) : r_count;
        n_str    = r_str;
        n_chr    = r_chr;
        n_esc    = r_esc;
        n_line   = r_line;
        n_block  = r_block;
        n_pslash = r_pslash;
        n_pstar  = r_pstar;
        if (!w_ovf) begin
            case (r_phase)
                PH_SEEK: begin
                    if (w_cls == CL_LBRACE) begin
                        w_phase_mid = PH_LEX;
                        n_depth  = DW'(1);
                        n_str    = 1'b0;
                        n_chr    = 1'b0;
                        n_esc    = 1'b0;
                        n_line   = 1'b0;
                        n_block  = 1'b0;
                        n_pslash = 1'b0;
                        n_pstar  = 1'b0;
                    end
                end
                PH_LEX: begin
                    if (r_line) begin
                        if (w_cls == CL_LF) begin
                            n_line = 1'b0;
                        end
                    end else if (r_block) begin
                        if (r_pstar && (w_cls == CL_SLASH)) begin
                            n_block = 1'b0;
                            n_pstar = 1'b0;
                        end else begin
                            n_pstar = (w_cls == CL_STAR);
                        end
                    end else if (r_str || r_chr) begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                        end else if (w_cls == CL_BSLASH) begin
                            n_esc = 1'b1;
                        end else if (r_str && (w_cls == CL_QUOTE)) begin
                            n_str = 1'b0;
                        end else if (r_chr && (w_cls == CL_APOS)) begin
                            n_chr = 1'b0;
                        end
                    end else if (r_pslash && (w_cls == CL_SLASH)) begin
                        n_pslash = 1'b0;
                        n_line   = 1'b1;
                    end else if (r_pslash && (w_cls == CL_STAR)) begin
                        n_pslash = 1'b0;
                        n_block  = 1'b1;
                    end else begin
                        n_pslash = (w_cls == CL_SLASH);
                        case (w_cls)
                            CL_QUOTE: n_str = 1'b1;
                            CL_APOS:  n_chr = 1'b1;
                            CL_LBRACE: begin
                                if (r_depth < DEPTH_LIM) begin
                                    n_depth = r_depth + DW'(1);
                                end
                            end
                            CL_RBRACE: begin
                                if (r_depth > DW'(1)) begin
                                    n_depth = r_depth - DW'(1);
                                end else begin
                                    n_depth     = '0;
                                    w_phase_mid = PH_AFTER_CLOSE;
                                end
                            end
                            default: n_depth = r_depth;
                        endcase
                    end
                end
                PH_AFTER_CLOSE: begin
                    if (w_cls == CL_CR) begin
                        w_phase_mid = PH_AFTER_CR;
                    end
                end
                default: w_phase_mid = r_phase;
            endcase
        end

        if (w_emit) begin
            n_phase = PH_DONE;
        end else begin
            n_phase = w_phase_mid;
        end
        if (w_last) begin
            n_phase  = PH_SEEK;
            n_depth  = '0;
            n_count  = '0;
            n_str    = 1'b0;
            n_chr    = 1'b0;
            n_esc    = 1'b0;
            n_line   = 1'b0;
            n_block  = 1'b0;
            n_pslash = 1'b0;
            n_pstar  = 1'b0;
        end
    end

    // outputs
    always_comb begin
        w_emit   = 1'b0;
        w_status = ST_FOUND;
        if (w_ovf || w_depth_ovf) begin
            w_emit   = 1'b1;
            w_status = ST_OVERFLOW;
        end else if ((r_phase == PH_AFTER_CLOSE && w_cls != CL_CR) ||
                     r_phase == PH_AFTER_CR) begin
            w_emit = 1'b1;
        end else if (w_last) begin
            case (w_phase_mid)
                PH_SEEK: begin
                    w_emit   = 1'b1;
                    w_status = ST_NO_OPEN;
                end
                PH_LEX: begin
                    w_emit   = 1'b1;
                    w_status = ST_UNCLOSED;
                end
                PH_AFTER_CLOSE, PH_AFTER_CR: begin
                    w_emit = 1'b1;
                end
                default: w_emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_start <= '0;
        end else if (i_cfg_we) begin
            r_span_start <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEEK;
            r_depth  <= '0;
            r_count  <= '0;
            r_str    <= 1'b0;
            r_chr    <= 1'b0;
            r_esc    <= 1'b0;
            r_line   <= 1'b0;
            r_block  <= 1'b0;
            r_pslash <= 1'b0;
            r_pstar  <= 1'b0;
        end else if (w_pop) begin
            r_phase  <= n_phase;
            r_depth  <= n_depth;
            r_count  <= n_count;
            r_str    <= n_str;
            r_chr    <= n_chr;
            r_esc    <= n_esc;
            r_line   <= n_line;
            r_block  <= n_block;
            r_pslash <= n_pslash;
            r_pstar  <= n_pstar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_emit) begin
            r_out_status <= w_status;
            r_out_span   <= (w_status == ST_FOUND) ? w_span : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_out_status;
    assign o_span_end = r_out_span;

endmodule
